>>> rtl/run_length_stack_with_capacity_core_defines.svh
// Assertion macros for the run-length stack core checker.
// No dependencies; included by the checker file only.
`ifndef RUN_LENGTH_STACK_WITH_CAPACITY_CORE_DEFINES_SVH
`define RUN_LENGTH_STACK_WITH_CAPACITY_CORE_DEFINES_SVH

// property must hold on every clock edge outside reset
`define RLSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define RLSC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/rlstk_pkg.sv
// Shared types, codes and default sizes for the run-length stack core.
// No dependencies; used by the interfaces, the top level, the ALU and the checker.
`default_nettype none

package rlstk_pkg;

	localparam int OP_W  = 2;
	localparam int CNT_W = 32;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CAP_W = 48;

	localparam int RUNS_DEF      = 1024;
	localparam int SIZE_BITS_DEF = 48;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [ST_W-1:0]  status_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [VAL_W-1:0] value_t;
	typedef logic [CAP_W-1:0] cap_t;
	typedef logic             alu_op_t;

	localparam op_t OP_PUSH = 2'd0;
	localparam op_t OP_POP  = 2'd1;
	localparam op_t OP_TOP  = 2'd2;
	localparam op_t OP_SIZE = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	localparam alu_op_t ALU_ADD = 1'b0;
	localparam alu_op_t ALU_SUB = 1'b1;

endpackage

`default_nettype wire

>>> rtl/rlstk_ifs.sv
// Valid/ready channel interfaces: command in, result out, capacity write.
// Depends on rlstk_pkg for payload types.
`default_nettype none

interface rlstk_in_if;
	logic               valid;
	logic               ready;
	rlstk_pkg::op_t     op;
	rlstk_pkg::count_t  count;
	rlstk_pkg::value_t  value;

	modport source (output valid, output op, output count, output value, input ready);
	modport sink   (input valid, input op, input count, input value, output ready);
endinterface

interface rlstk_out_if;
	logic                valid;
	logic                ready;
	rlstk_pkg::status_t  status;
	rlstk_pkg::cap_t     data;

	modport source (output valid, output status, output data, input ready);
	modport sink   (input valid, input status, input data, output ready);
endinterface

interface rlstk_cfg_if;
	logic             valid;
	logic             ready;
	rlstk_pkg::cap_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/run_length_stack_with_capacity_core.sv
// Run-length stack top level: sequencer, state registers, run store and shared ALU.
// Depends on rlstk_pkg, rlstk_ifs, rlstk_ram and rlstk_alu.
//
//   channel  | dir | payload              | transfer
//   ---------+-----+----------------------+----------------------
//   in_ch    | in  | op, count, value     | valid & ready
//   out_ch   | out | status, data         | valid & ready
//   cfg_ch   | in  | data (capacity)      | valid & ready (ready always high)
//
// Path from accept to the result register: size, a sticky error, a zero-count push,
// a zero or oversized pop and a top on empty go from IDLE straight to DONE; other
// pushes pass PUSH_CHK, tops TOP_WAIT; other pops run RD and CMP per run walked, then
// TRIM when the last run is trimmed, due to the registered read and the shared adder.
// in_ch.ready is high only while idle; a finished result may wait in out_ch.
// Reset clears control state; the run store has no clearing pass.
`default_nettype none

module run_length_stack_with_capacity_core #(
	parameter int RUNS      = rlstk_pkg::RUNS_DEF,
	parameter int SIZE_BITS = rlstk_pkg::SIZE_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rlstk_in_if.sink     in_ch,
	rlstk_out_if.source  out_ch,
	rlstk_cfg_if.sink    cfg_ch
);
	import rlstk_pkg::*;

	localparam int TW    = $clog2(RUNS + 1);
	localparam int AW    = $clog2(RUNS);
	localparam int SUM_W = ((SIZE_BITS > CAP_W) ? SIZE_BITS : CAP_W) + 1;
	localparam int ENT_W = VAL_W + CNT_W;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PUSH_CHK = 3'd1;
	localparam logic [2:0] S_RD       = 3'd2;
	localparam logic [2:0] S_CMP      = 3'd3;
	localparam logic [2:0] S_TRIM     = 3'd4;
	localparam logic [2:0] S_TOP_WAIT = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0]           state_q, state_d;
	logic [TW-1:0]        run_top_q, run_top_d, top_m1;
	logic [SIZE_BITS-1:0] total_q, total_d;
	status_t              err_q, err_d;
	cap_t                 capacity_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	cap_t                 out_data_q;

	status_t              res_status_q, res_status_d;
	cap_t                 res_data_q, res_data_d;
	count_t               cnt_q, cnt_d;
	value_t               val_q, val_d;
	logic [SUM_W-1:0]     sum_q, sum_d;

	alu_op_t              alu_op;
	logic [SUM_W-1:0]     alu_a, alu_b, alu_res;
	logic                 alu_co;

	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, top_idx;
	logic [ENT_W-1:0]     wr_data, rd_data;
	value_t               rd_val;
	count_t               rd_cnt;
	logic                 out_load;

	assign top_m1  = run_top_q - TW'(1);
	assign top_idx = top_m1[AW-1:0];
	assign rd_val  = rd_data[ENT_W-1:CNT_W];
	assign rd_cnt  = rd_data[CNT_W-1:0];

	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = out_status_q;
	assign out_ch.data   = out_data_q;

	rlstk_alu #(.W(SUM_W)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.co  (alu_co)
	);

	rlstk_ram #(.WIDTH(ENT_W), .DEPTH(RUNS)) u_runs (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (top_idx),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d      = state_q;
		run_top_d    = run_top_q;
		total_d      = total_q;
		err_d        = err_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		cnt_d        = cnt_q;
		val_d        = val_q;
		sum_d        = sum_q;
		alu_op       = ALU_ADD;
		alu_a        = SUM_W'(total_q);
		alu_b        = SUM_W'(in_ch.count);
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = top_idx;
		wr_data      = {val_q, cnt_q};

		unique case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					res_status_d = ST_OK;
					res_data_d   = '0;
					cnt_d        = in_ch.count;
					val_d        = in_ch.value;
					if (err_q != ST_OK) begin
						res_status_d = err_q;
						state_d      = S_DONE;
					end else begin
						unique case (in_ch.op)
							OP_PUSH: begin
								sum_d   = alu_res;
								state_d = (in_ch.count == '0) ? S_DONE : S_PUSH_CHK;
							end
							OP_POP: begin
								alu_op = ALU_SUB;
								if (alu_co) begin
									err_d        = ST_EMPTY;
									res_status_d = ST_EMPTY;
									state_d      = S_DONE;
								end else begin
									total_d = alu_res[SIZE_BITS-1:0];
									state_d = (in_ch.count == '0) ? S_DONE : S_RD;
								end
							end
							OP_TOP: begin
								if (total_q == '0 || run_top_q == '0) begin
									err_d        = ST_EMPTY;
									res_status_d = ST_EMPTY;
									state_d      = S_DONE;
								end else begin
									rd_en   = 1'b1;
									state_d = S_TOP_WAIT;
								end
							end
							OP_SIZE: begin
								res_data_d = CAP_W'(total_q);
								state_d    = S_DONE;
							end
						endcase
					end
				end
			end
			S_PUSH_CHK: begin
				alu_op = ALU_SUB;
				alu_a  = SUM_W'(capacity_q);
				alu_b  = sum_q;
				if (alu_co || (|sum_q[SUM_W-1:SIZE_BITS]) || run_top_q == TW'(RUNS)) begin
					err_d        = ST_FULL;
					res_status_d = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = run_top_q[AW-1:0];
					run_top_d = run_top_q + TW'(1);
					total_d   = sum_q[SIZE_BITS-1:0];
				end
				state_d = S_DONE;
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = SUM_W'(cnt_q);
				alu_b  = SUM_W'(rd_cnt);
				if (alu_co) begin
					state_d = S_TRIM;
				end else begin
					cnt_d     = alu_res[CNT_W-1:0];
					run_top_d = top_m1;
					state_d   = (alu_res == '0) ? S_DONE : S_RD;
				end
			end
			S_TRIM: begin
				alu_op  = ALU_SUB;
				alu_a   = SUM_W'(rd_cnt);
				alu_b   = SUM_W'(cnt_q);
				wr_en   = 1'b1;
				wr_data = {rd_val, alu_res[CNT_W-1:0]};
				state_d = S_DONE;
			end
			S_TOP_WAIT: begin
				res_data_d = CAP_W'(rd_val);
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_top_q   <= '0;
			total_q     <= '0;
			err_q       <= ST_OK;
			capacity_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			run_top_q <= run_top_d;
			total_q   <= total_d;
			err_q     <= err_d;
			if (cfg_ch.valid) begin
				capacity_q <= cfg_ch.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		cnt_q        <= cnt_d;
		val_q        <= val_d;
		sum_q        <= sum_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rlstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlstk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/rlstk_alu.sv
// Shared add/subtract unit with carry-out (add) or borrow-out (subtract).
// Depends on rlstk_pkg for the operation codes.
`default_nettype none

module rlstk_alu #(
	parameter int W = 49
) (
	input  wire rlstk_pkg::alu_op_t op,
	input  wire logic [W-1:0]       a,
	input  wire logic [W-1:0]       b,
	output logic      [W-1:0]       res,
	output logic                    co
);
	import rlstk_pkg::*;

	always_comb begin
		unique case (op)
			ALU_SUB: {co, res} = {1'b0, a} - {1'b0, b};
			default: {co, res} = {1'b0, a} + {1'b0, b};
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/rlstk_chk.sv
// Port-level checker for the run-length stack core, bound to the top level.
// Depends on rlstk_pkg and the assertion macros header.
`default_nettype none

`include "run_length_stack_with_capacity_core_defines.svh"

module rlstk_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire rlstk_pkg::status_t out_status,
	input wire rlstk_pkg::cap_t    out_data
);
	import rlstk_pkg::*;

	logic    err_seen_q;
	status_t err_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			err_code_q <= ST_OK;
		end else if (out_valid && out_ready && !err_seen_q && out_status != ST_OK) begin
			err_seen_q <= 1'b1;
			err_code_q <= out_status;
		end
	end

	`RLSC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`RLSC_ASSERT(a_err_sticky, clk, arst_n, out_valid && err_seen_q |-> out_status == err_code_q, "sticky error lost or changed")
	`RLSC_NEVER(a_err_data, clk, arst_n, out_valid && out_status != ST_OK && out_data != '0, "error result carries data")
	`RLSC_ASSERT(a_one_item, clk, arst_n, in_valid && in_ready |=> !in_ready, "second item taken while busy")

endmodule

bind run_length_stack_with_capacity_core rlstk_chk u_rlstk_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.status),
	.out_data   (out_ch.data)
);

`default_nettype wire
